// File: hw/rtl/dnc_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the month length table for the day number to date block
// no dependencies; dnc_seq, dnc_dp and the top level import this package

package dnc_pkg;

  localparam int CountWidth = 22;
  localparam int YearWidth  = 14;
  localparam int MulAWidth  = 22;
  localparam int MulBWidth  = 30;
  localparam int ProdWidth  = MulAWidth + MulBWidth;

  localparam logic [CountWidth-1:0] LAST_VALID_DAY = 22'd3652058;

  // reciprocals for exact constant division over the ranges used here
  localparam logic [MulBWidth-1:0] RECIP_366 = 30'd11734884;  // x / 366 = (x * r) >> 32
  localparam logic [MulBWidth-1:0] RECIP_7   = 30'd613566757; // x / 7   = (x * r) >> 32
  localparam logic [MulBWidth-1:0] RECIP_100 = 30'd10486;     // y / 100 = (y * r) >> 20
  localparam logic [MulBWidth-1:0] DAYS_YEAR_MUL = 30'd365;

  localparam logic [8:0] DAYS_365 = 9'd365;
  localparam logic [8:0] DAYS_366 = 9'd366;
  localparam logic [6:0] CENT_LAST = 7'd99;
  localparam logic [3:0] MONTH_LAST = 4'd11;

  typedef struct packed {
    logic [CountWidth-1:0] base_days;
  } in_beat_t;

  typedef struct packed {
    logic [YearWidth-1:0] year;
    logic [3:0]           month;
    logic [4:0]           day_of_month;
    logic [8:0]           day_of_year;
    logic [2:0]           weekday;
    logic                 out_of_range;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV366,
    ST_DIV7,
    ST_MUL365,
    ST_DIV100,
    ST_CENT,
    ST_ADV,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  typedef struct packed {
    state_t step;
    logic   load;
    logic   out_load;
  } ctrl_t;

  typedef struct packed {
    logic oor;
    logic year_fit;
    logic month_fit;
  } status_t;

  function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
    logic [4:0] len;
    case (idx)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: hw/rtl/dnc_stream_if.sv
`timescale 1ns / 1ps
// valid/ready stream channel with a typed payload
// payload types come from dnc_pkg at the point of instantiation

interface dnc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/dnc_seq.sv
`timescale 1ns / 1ps
// sequencer: steps the shared multiplier and adder through estimate, year and month walk
// depends on dnc_pkg

module dnc_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_ready,
  input  dnc_pkg::status_t status,
  output dnc_pkg::ctrl_t   ctrl,
  output logic             in_ready,
  output logic             out_valid
);
  import dnc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    ctrl.step     = state;
    ctrl.load     = 1'b0;
    ctrl.out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = status.oor ? ST_DONE : ST_DIV366;
        end
      end
      ST_DIV366: state_next = ST_DIV7;
      ST_DIV7:   state_next = ST_MUL365;
      ST_MUL365: state_next = ST_DIV100;
      ST_DIV100: state_next = ST_CENT;
      ST_CENT:   state_next = ST_ADV;
      ST_ADV:    state_next = ST_YEAR;
      ST_YEAR: begin
        if (status.year_fit) begin
          state_next = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (status.month_fit) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the result here until the output register frees up
        if (!out_valid || out_ready) begin
          ctrl.out_load = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result beat appeared outside the done step");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |=> out_valid)
    else $error("loaded result not presented");

endmodule

// File: hw/rtl/dnc_dp.sv
`timescale 1ns / 1ps
// datapath: one shared multiplier with a registered product, the remainder adder,
// year and century counters and the result register; depends on dnc_pkg

module dnc_dp (
  input  logic               clk,
  input  logic               rst,
  input  dnc_pkg::ctrl_t     ctrl,
  input  dnc_pkg::in_beat_t  in_data,
  output dnc_pkg::status_t   status,
  output dnc_pkg::out_beat_t out_data
);
  import dnc_pkg::*;

  logic [CountWidth-1:0] rem1;
  logic [CountWidth-1:0] rem;
  logic [ProdWidth-1:0]  prod;
  logic [YearWidth-1:0]  year_r;
  logic [18:0]           q7;
  logic [2:0]            wd;
  logic [6:0]            m100;
  logic [1:0]            cm4;
  logic [3:0]            mi;
  logic [3:0]            mon;
  logic [4:0]            mday;
  logic [8:0]            doy;
  logic                  oor_r;

  logic [MulAWidth-1:0]  mul_a;
  logic [MulBWidth-1:0]  mul_b;
  logic                  leap;
  logic [8:0]            year_len;
  logic [4:0]            mlen;
  logic [6:0]            cent;
  logic [CountWidth-1:0] rem_dec;
  logic [CountWidth-1:0] q7_times7;

  assign leap      = (year_r[1:0] == 2'd0) && ((m100 != 7'd0) || (cm4 == 2'd0));
  assign year_len  = leap ? DAYS_366 : DAYS_365;
  assign mlen      = month_len(mi, leap);
  assign cent      = prod[26:20];
  assign rem_dec   = rem - 22'd1;
  assign q7_times7 = {q7, 3'b000} - {3'b000, q7};

  assign status.oor       = in_data.base_days > LAST_VALID_DAY;
  assign status.year_fit  = rem <= {13'd0, year_len};
  assign status.month_fit = rem <= {17'd0, mlen};

  // operand select for the shared multiplier
  always_comb begin
    mul_a = rem1;
    mul_b = RECIP_366;
    case (ctrl.step)
      ST_DIV366: begin
        mul_a = rem1;
        mul_b = RECIP_366;
      end
      ST_DIV7: begin
        mul_a = rem1;
        mul_b = RECIP_7;
      end
      ST_MUL365: begin
        mul_a = {8'd0, year_r};
        mul_b = DAYS_YEAR_MUL;
      end
      ST_DIV100: begin
        mul_a = {8'd0, year_r};
        mul_b = RECIP_100;
      end
      default: begin
        mul_a = rem1;
        mul_b = RECIP_366;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (ctrl.step)
      ST_IDLE: begin
        if (ctrl.load) begin
          rem1  <= in_data.base_days + 22'd1;
          oor_r <= status.oor;
        end
      end
      ST_DIV366: prod <= mul_a * mul_b;
      ST_DIV7: begin
        year_r <= prod[45:32];
        prod   <= mul_a * mul_b;
      end
      ST_MUL365: begin
        q7   <= prod[50:32];
        prod <= mul_a * mul_b;
      end
      ST_DIV100: begin
        wd   <= 3'(rem1 - q7_times7);
        rem  <= rem1 - prod[CountWidth-1:0];
        prod <= mul_a * mul_b;
      end
      ST_CENT: begin
        // finish the leap-day count of the estimate: - y/4 + y/100 - y/400
        rem  <= rem + {15'd0, cent} - {10'd0, year_r[13:2]} - {17'd0, cent[6:2]};
        m100 <= 7'(year_r - ({7'd0, cent} * 14'd100));
        cm4  <= cent[1:0];
      end
      ST_ADV, ST_YEAR: begin
        if (ctrl.step == ST_ADV || !status.year_fit) begin
          if (ctrl.step == ST_YEAR) begin
            rem <= rem - {13'd0, year_len};
          end
          year_r <= year_r + 14'd1;
          if (m100 == CENT_LAST) begin
            m100 <= 7'd0;
            cm4  <= cm4 + 2'd1;
          end else begin
            m100 <= m100 + 7'd1;
          end
        end else begin
          doy <= rem_dec[8:0];
          mi  <= 4'd0;
        end
      end
      ST_MONTH: begin
        if (status.month_fit) begin
          mon  <= mi + 4'd1;
          mday <= rem[4:0];
        end else begin
          rem <= rem - {17'd0, mlen};
          mi  <= mi + 4'd1;
        end
      end
      ST_DONE: begin
        if (ctrl.out_load) begin
          out_data.out_of_range <= oor_r;
          out_data.year         <= oor_r ? 14'd0 : year_r;
          out_data.month        <= oor_r ? 4'd0 : mon;
          out_data.day_of_month <= oor_r ? 5'd0 : mday;
          out_data.day_of_year  <= oor_r ? 9'd0 : doy;
          out_data.weekday      <= oor_r ? 3'd0 : wd;
        end
      end
      default: begin
      end
    endcase
  end

  a_year_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl.step == ST_YEAR |-> year_r <= 14'd9999)
    else $error("year walk ran past the last year");

  a_month_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl.step == ST_MONTH |-> mi <= MONTH_LAST)
    else $error("month walk ran past december");

  a_cent_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl.step == ST_YEAR |-> m100 <= CENT_LAST)
    else $error("year within century out of range");

endmodule

// File: hw/rtl/day_number_to_civil_date.sv
`timescale 1ns / 1ps
// Day count to proleptic Gregorian date converter.
//
// day_in carries one beat per conversion: base_days, days since 1 January of year 1.
// date_out returns one beat per input with year, month, day_of_month, day_of_year,
// weekday (0 is Sunday) and out_of_range. Counts past 31 December 9999 give
// out_of_range set and every other field zero.
//
// One multiplier and one remainder adder are stepped by a small sequencer:
// four multiply steps form the year estimate, the weekday and the leap-day count,
// then the year is advanced one per cycle (up to about 22) and the months walked one
// per cycle (up to 12). Only one conversion is in flight, and the sequencer returns to
// idle before it takes the next beat; an out-of-range count goes straight from idle to
// the done step.
//
// day_in.ready is high while the sequencer is idle, even if a result still waits on
// date_out. If date_out stalls, the finished result waits in the sequencer until the
// output register is free. Reset (rst, synchronous) returns to idle and drops
// date_out.valid.
// depends on dnc_pkg, dnc_stream_if, dnc_seq and dnc_dp

module day_number_to_civil_date (
  input logic          clk,
  input logic          rst,
  dnc_stream_if.sink   day_in,
  dnc_stream_if.source date_out
);
  import dnc_pkg::*;

  ctrl_t     ctrl;
  status_t   status;
  in_beat_t  in_data;
  out_beat_t out_data;
  logic      in_ready;
  logic      out_valid;

  assign in_data        = day_in.data;
  assign day_in.ready   = in_ready;
  assign date_out.valid = out_valid;
  assign date_out.data  = out_data;

  dnc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (day_in.valid),
    .out_ready (date_out.ready),
    .status    (status),
    .ctrl      (ctrl),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  dnc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .in_data  (in_data),
    .status   (status),
    .out_data (out_data)
  );

endmodule
